>>> sv/tnt_pkg.sv
// tnt_pkg: shared constants and types for the triangle normal / tangent pipeline
// used by tnt_unitize and triangle_normal_tangent; no dependencies
`default_nettype none
package tnt_pkg;
    localparam int INDEX_BITS_DEF     = 16;
    localparam int COMPONENT_BITS_DEF = 16;
    localparam int UV_BITS            = 16;
    localparam int OUT_BITS           = 16;
    // widest vector component entering a unitizer (cross product, tangent)
    localparam int VEC_BITS           = 48;
    localparam int MAG_BITS           = 30;
    localparam int SUM_BITS           = 62;
    localparam int ROOT_BITS          = 31;
    localparam int QUO_BITS           = 15;
    localparam int UNIT_ONE           = 16384;

    typedef logic [MAG_BITS-1:0] mag_t;
endpackage
`default_nettype wire

>>> sv/tnt_unitize.sv
// tnt_unitize: pipelined unit-vector unit (normalize, square sum, root, divide)
// depends on tnt_pkg; stage count is fixed, stall by a common enable
`default_nettype none
module tnt_unitize (
    input  wire logic                                aclk,
    input  wire logic                                en,
    input  wire logic signed [tnt_pkg::VEC_BITS-1:0] vec_x,
    input  wire logic signed [tnt_pkg::VEC_BITS-1:0] vec_y,
    input  wire logic signed [tnt_pkg::VEC_BITS-1:0] vec_z,
    output logic signed [tnt_pkg::OUT_BITS-1:0]      unit_x,
    output logic signed [tnt_pkg::OUT_BITS-1:0]      unit_y,
    output logic signed [tnt_pkg::OUT_BITS-1:0]      unit_z,
    output logic                                     zero
);
    localparam int VB = tnt_pkg::VEC_BITS;
    localparam int MB = tnt_pkg::MAG_BITS;
    localparam int SB = tnt_pkg::SUM_BITS;
    localparam int RB = tnt_pkg::ROOT_BITS;
    localparam int QB = tnt_pkg::QUO_BITS;
    localparam int SQ_STEPS = RB;       // one root bit per stage
    localparam int DV_STEPS = QB + 1;   // quotient bits 15..0

    // stage 1: magnitude and sign
    logic [VB-1:0] ma_reg [3];
    logic [2:0]    neg1_reg;
    logic [VB-1:0] ma_c [3];
    logic [VB-1:0] mx_c;
    logic [5:0]    lead_c;
    always_comb begin
        ma_c[0] = vec_x[VB-1] ? VB'(-vec_x) : VB'(vec_x);
        ma_c[1] = vec_y[VB-1] ? VB'(-vec_y) : VB'(vec_y);
        ma_c[2] = vec_z[VB-1] ? VB'(-vec_z) : VB'(vec_z);
    end
    always_ff @(posedge aclk) if (en) begin
        ma_reg   <= ma_c;
        neg1_reg <= {vec_z[VB-1], vec_y[VB-1], vec_x[VB-1]};
    end

    // stage 2: find top bit of the largest magnitude and shift so it sits at bit 29
    always_comb begin
        mx_c = ma_reg[0] | ma_reg[1] | ma_reg[2];
        lead_c = '0;
        for (int i = 0; i < VB; i++) if (mx_c[i]) lead_c = 6'(i);
    end
    logic [MB-1:0] m2_reg [3];
    logic [2:0]    neg2_reg;
    logic          z2_reg;
    always_ff @(posedge aclk) if (en) begin
        for (int k = 0; k < 3; k++) begin
            if (lead_c >= 6'(MB-1))
                m2_reg[k] <= MB'(ma_reg[k] >> (lead_c - 6'(MB-1)));
            else
                m2_reg[k] <= MB'(ma_reg[k] << (6'(MB-1) - lead_c));
        end
        neg2_reg <= neg1_reg;
        z2_reg   <= (mx_c == '0);
    end

    // stage 3: square sum (three 30x30 products)
    logic [SB-1:0] sum3_reg;
    logic [MB-1:0] m3_reg [3];
    logic [2:0]    neg3_reg;
    logic          z3_reg;
    always_ff @(posedge aclk) if (en) begin
        sum3_reg <= SB'(m2_reg[0] * m2_reg[0]) + SB'(m2_reg[1] * m2_reg[1])
                  + SB'(m2_reg[2] * m2_reg[2]);
        m3_reg   <= m2_reg;
        neg3_reg <= neg2_reg;
        z3_reg   <= z2_reg;
    end

    // square root, one result bit per stage (restoring)
    logic [SB-1:0] sq_rem [SQ_STEPS+1];
    logic [RB-1:0] sq_root [SQ_STEPS+1];
    logic [MB-1:0] sq_m [SQ_STEPS+1][3];
    logic [2:0]    sq_neg [SQ_STEPS+1];
    logic          sq_z [SQ_STEPS+1];
    assign sq_rem[0] = sum3_reg;
    assign sq_root[0] = '0;
    assign sq_m[0] = m3_reg;
    assign sq_neg[0] = neg3_reg;
    assign sq_z[0] = z3_reg;
    for (genvar s = 0; s < SQ_STEPS; s++) begin : g_sq
        localparam int B = RB - 1 - s;
        logic [SB+1:0] trial;
        logic [SB-1:0] rem_reg;
        logic [RB-1:0] root_reg;
        logic [MB-1:0] m_reg [3];
        logic [2:0]    neg_reg;
        logic          z_reg;
        // candidate (root + 2^B)^2 - root^2 = (2*root + 2^B) * 2^B
        assign trial = ((SB+2)'(sq_root[s]) << (B + 1)) + ((SB+2)'(1) << (2 * B));
        always_ff @(posedge aclk) if (en) begin
            if (trial <= (SB+2)'(sq_rem[s])) begin
                rem_reg  <= SB'((SB+2)'(sq_rem[s]) - trial);
                root_reg <= sq_root[s] | (RB'(1) << B);
            end else begin
                rem_reg  <= sq_rem[s];
                root_reg <= sq_root[s];
            end
            m_reg   <= sq_m[s];
            neg_reg <= sq_neg[s];
            z_reg   <= sq_z[s];
        end
        assign sq_rem[s+1] = rem_reg;
        assign sq_root[s+1] = root_reg;
        assign sq_m[s+1] = m_reg;
        assign sq_neg[s+1] = neg_reg;
        assign sq_z[s+1] = z_reg;
    end

    // divide: q = floor((2*m*2^14 + r) / (2r)), one quotient bit per stage, three lanes
    localparam int NB = MB + QB + 2;
    logic [NB-1:0] dv_num [DV_STEPS+1][3];
    logic [QB:0]   dv_q   [DV_STEPS+1][3];
    logic [RB:0]   dv_den [DV_STEPS+1];
    logic [2:0]    dv_neg [DV_STEPS+1];
    logic          dv_z [DV_STEPS+1];
    logic [RB-1:0] r_fin;
    assign r_fin = sq_root[SQ_STEPS];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dv_num[0][k] = (NB'(sq_m[SQ_STEPS][k]) << (QB)) + NB'(r_fin);
            dv_q[0][k] = '0;
        end
    end
    assign dv_den[0] = {r_fin, 1'b0};
    assign dv_neg[0] = sq_neg[SQ_STEPS];
    assign dv_z[0] = sq_z[SQ_STEPS];
    for (genvar s = 0; s < DV_STEPS; s++) begin : g_dv
        localparam int B = QB - s;
        logic [NB-1:0] num_reg [3];
        logic [QB:0]   q_reg [3];
        logic [RB:0]   den_reg;
        logic [2:0]    neg_reg;
        logic          z_reg;
        always_ff @(posedge aclk) if (en) begin
            for (int k = 0; k < 3; k++) begin
                if ((dv_num[s][k] >> B) >= NB'(dv_den[s])) begin
                    num_reg[k] <= dv_num[s][k] - (NB'(dv_den[s]) << B);
                    q_reg[k]   <= dv_q[s][k] | ((QB+1)'(1) << B);
                end else begin
                    num_reg[k] <= dv_num[s][k];
                    q_reg[k]   <= dv_q[s][k];
                end
            end
            den_reg <= dv_den[s];
            neg_reg <= dv_neg[s];
            z_reg   <= dv_z[s];
        end
        assign dv_num[s+1] = num_reg;
        assign dv_q[s+1] = q_reg;
        assign dv_den[s+1] = den_reg;
        assign dv_neg[s+1] = neg_reg;
        assign dv_z[s+1] = z_reg;
    end

    logic signed [15:0] o_c [3];
    always_comb begin
        for (int k = 0; k < 3; k++)
            o_c[k] = dv_neg[DV_STEPS][k] ? 16'(-$signed({1'b0, dv_q[DV_STEPS][k]}))
                                         : 16'($signed({1'b0, dv_q[DV_STEPS][k]}));
    end
    assign unit_x = o_c[0];
    assign unit_y = o_c[1];
    assign unit_z = o_c[2];
    assign zero = dv_z[DV_STEPS];
endmodule
`default_nettype wire

>>> sv/triangle_normal_tangent.sv
// triangle_normal_tangent: per-face unit normal and tangent of a triangle stream
// depends on tnt_pkg and tnt_unitize
`default_nettype none
// usage:
//   s_ channel: one triangle per request (indices, packed positions, packed uvs)
//   m_ channel: one result per request (indices, unit normal, unit tangent, flag)
//   pipeline: 3 front stages (edges, products, sign fix) plus 50 unitizer stages
//     plus the output register
//   throughput: one triangle per cycle; set by the fully pipelined unitizer,
//     which resolves one square-root bit and one quotient bit per stage
//   stall: the whole pipeline holds while the output register is full and
//     m_ready is low; s_ready is high whenever the output can move or the
//     output slot is empty, so nothing is dropped or repeated
//   reset: aresetn low clears all valid bits; data registers are not reset
//   a zero cross product, zero tangent or zero uv determinant sets
//   degenerate and zeros all six vector components
module triangle_normal_tangent #(
    parameter int INDEX_BITS     = tnt_pkg::INDEX_BITS_DEF,
    parameter int COMPONENT_BITS = tnt_pkg::COMPONENT_BITS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [INDEX_BITS-1:0]     s_index_a,
    input  wire logic [INDEX_BITS-1:0]     s_index_b,
    input  wire logic [INDEX_BITS-1:0]     s_index_c,
    input  wire logic [3*COMPONENT_BITS-1:0] s_position_a,
    input  wire logic [3*COMPONENT_BITS-1:0] s_position_b,
    input  wire logic [3*COMPONENT_BITS-1:0] s_position_c,
    input  wire logic [31:0]               s_uv_a,
    input  wire logic [31:0]               s_uv_b,
    input  wire logic [31:0]               s_uv_c,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [INDEX_BITS-1:0]          m_out_index_a,
    output logic [INDEX_BITS-1:0]          m_out_index_b,
    output logic [INDEX_BITS-1:0]          m_out_index_c,
    output logic signed [15:0]             m_normal_x,
    output logic signed [15:0]             m_normal_y,
    output logic signed [15:0]             m_normal_z,
    output logic signed [15:0]             m_tangent_x,
    output logic signed [15:0]             m_tangent_y,
    output logic signed [15:0]             m_tangent_z,
    output logic                           m_degenerate
);
    localparam int CB = COMPONENT_BITS;
    localparam int DB = CB + 1;            // edge width
    localparam int UB = tnt_pkg::UV_BITS + 1;
    localparam int VB = tnt_pkg::VEC_BITS;
    localparam int UNIT_STAGES = tnt_pkg::ROOT_BITS + tnt_pkg::QUO_BITS + 1 + 3;
    localparam int LAT = 3 + UNIT_STAGES;  // stages before the output register

    // one enable for the whole pipe: advance unless the output slot is stuck
    logic en;
    assign en = !m_valid || m_ready;
    assign s_ready = en;

    // valid bits and index pass-through ride alongside the data
    logic [LAT-1:0] vld_reg;
    logic [3*INDEX_BITS-1:0] idx_reg [LAT];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end
    always_ff @(posedge aclk) if (en) begin
        idx_reg[0] <= {s_index_c, s_index_b, s_index_a};
        for (int i = 1; i < LAT; i++) idx_reg[i] <= idx_reg[i-1];
    end

    // stage 1: edge vectors in position and uv space
    logic signed [DB-1:0] d1_reg [3], d2_reg [3];
    logic signed [UB-1:0] e1_reg [2], e2_reg [2];
    always_ff @(posedge aclk) if (en) begin
        for (int k = 0; k < 3; k++) begin
            d1_reg[k] <= DB'($signed(s_position_b[k*CB +: CB]))
                       - DB'($signed(s_position_a[k*CB +: CB]));
            d2_reg[k] <= DB'($signed(s_position_c[k*CB +: CB]))
                       - DB'($signed(s_position_a[k*CB +: CB]));
        end
        for (int k = 0; k < 2; k++) begin
            e1_reg[k] <= UB'($signed(s_uv_b[k*16 +: 16])) - UB'($signed(s_uv_a[k*16 +: 16]));
            e2_reg[k] <= UB'($signed(s_uv_c[k*16 +: 16])) - UB'($signed(s_uv_a[k*16 +: 16]));
        end
    end

    // stage 2: all the products
    logic signed [VB-1:0] p_reg [12];
    always_ff @(posedge aclk) if (en) begin
        p_reg[0]  <= VB'(d1_reg[1] * d2_reg[2]);
        p_reg[1]  <= VB'(d1_reg[2] * d2_reg[1]);
        p_reg[2]  <= VB'(d1_reg[2] * d2_reg[0]);
        p_reg[3]  <= VB'(d1_reg[0] * d2_reg[2]);
        p_reg[4]  <= VB'(d1_reg[0] * d2_reg[1]);
        p_reg[5]  <= VB'(d1_reg[1] * d2_reg[0]);
        p_reg[6]  <= VB'(e1_reg[0] * e2_reg[1]);
        p_reg[7]  <= VB'(e1_reg[1] * e2_reg[0]);
        for (int k = 0; k < 3; k++)
            p_reg[8+k] <= VB'(d1_reg[k] * e2_reg[1]) - VB'(d2_reg[k] * e1_reg[1]);
        p_reg[11] <= '0;
    end

    // stage 3: cross product, determinant sign, tangent sign fix
    logic signed [VB-1:0] cr_reg [3], tv_reg [3];
    logic signed [VB-1:0] det_c;
    logic [UNIT_STAGES:0] dz_reg;  // determinant zero, carried to the end
    assign det_c = p_reg[6] - p_reg[7];
    always_ff @(posedge aclk) if (en) begin
        cr_reg[0] <= p_reg[0] - p_reg[1];
        cr_reg[1] <= p_reg[2] - p_reg[3];
        cr_reg[2] <= p_reg[4] - p_reg[5];
        for (int k = 0; k < 3; k++)
            tv_reg[k] <= det_c[VB-1] ? -p_reg[8+k] : p_reg[8+k] + p_reg[11];
        dz_reg <= {dz_reg[UNIT_STAGES-1:0], det_c == '0};
    end

    logic signed [15:0] nu [3], tu [3];
    logic nz, tz;
    tnt_unitize u_norm (
        .aclk(aclk), .en(en),
        .vec_x(cr_reg[0]), .vec_y(cr_reg[1]), .vec_z(cr_reg[2]),
        .unit_x(nu[0]), .unit_y(nu[1]), .unit_z(nu[2]), .zero(nz)
    );
    tnt_unitize u_tan (
        .aclk(aclk), .en(en),
        .vec_x(tv_reg[0]), .vec_y(tv_reg[1]), .vec_z(tv_reg[2]),
        .unit_x(tu[0]), .unit_y(tu[1]), .unit_z(tu[2]), .zero(tz)
    );

    // output register
    logic ok;
    logic [3*INDEX_BITS-1:0] idx_out;
    assign ok = !nz && !tz && !dz_reg[UNIT_STAGES];
    assign idx_out = idx_reg[LAT-1];
    logic m_valid_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (en) m_valid_reg <= vld_reg[LAT-1];
    end
    always_ff @(posedge aclk) if (en) begin
        m_out_index_a <= idx_out[0 +: INDEX_BITS];
        m_out_index_b <= idx_out[INDEX_BITS +: INDEX_BITS];
        m_out_index_c <= idx_out[2*INDEX_BITS +: INDEX_BITS];
        m_normal_x  <= ok ? nu[0] : '0;
        m_normal_y  <= ok ? nu[1] : '0;
        m_normal_z  <= ok ? nu[2] : '0;
        m_tangent_x <= ok ? tu[0] : '0;
        m_tangent_y <= ok ? tu[1] : '0;
        m_tangent_z <= ok ? tu[2] : '0;
        m_degenerate <= !ok;
    end
    assign m_valid = m_valid_reg;
endmodule
`default_nettype wire
